// File: sv/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and constants of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int DefStackDepth = 64;
  localparam int DefValueWidth = 32;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChMul   = 8'h2A;
  localparam logic [7:0] ChDiv   = 8'h2F;
  localparam logic [7:0] ChMod   = 8'h25;
  localparam logic [7:0] ChOr    = 8'h7C;
  localparam logic [7:0] ChAnd   = 8'h26;
  localparam logic [7:0] ChXor   = 8'h5E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChNl    = 8'h0A;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StUnder = 2'd1;
  localparam logic [1:0] StDivZ  = 2'd2;
  localparam logic [1:0] StOver  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,     // wait for a character
    S_PUSHNUM,  // fold a digit or push the finished literal
    S_PENDSUB,  // start the held subtraction
    S_RDP,      // read top
    S_RDQ,      // read next, latch p
    S_EXEC,     // latch q, start the operation
    S_DIV,      // iterate the divider
    S_PUSHRES,  // push the result
    S_DISPATCH, // handle the character itself
    S_RDTOP,    // read top for newline
    S_EMIT,     // present the result
    S_WAITOUT   // hold until the output register is free
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_char;   // latch the input character
    logic digit;       // fold the latched digit into the accumulator
    logic push_num;    // push the literal
    logic set_minus;   // hold a minus
    logic clr_minus;   // the held minus was consumed
    logic use_sub;     // operate with subtraction instead of the latched char
    logic rd_top;      // read address sp-1
    logic rd_next;     // read address sp-2
    logic latch_p;
    logic latch_q;
    logic start_op;    // compute result, start the divider when needed
    logic div_step;
    logic push_res;
    logic underflow;   // flag underflow
    logic emit;        // load the output register and clear the line
  } pfe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_digit;
    logic is_minus;
    logic is_op;
    logic is_nl;
    logic in_number;
    logic minus_pending;
    logic sp_ge2;
    logic sp_ge1;
    logic is_divop;
    logic div_done;
    logic out_busy;
  } pfe_sts_t;

endpackage

// File: sv/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// RPN evaluator over an ASCII character stream with an operand stack.
// ----------------------------------------------------------------------------
// Usage:
//   Feed one ASCII character per request on s_axis (tdata = char_in).
//   Digits build literals; '-' right before a digit marks a negative literal,
//   otherwise it subtracts. + - * / % | & ^ pop two and push q op p.
//   A newline (10) produces one request on m_axis with the top of stack and
//   the first error of the line, then clears the stack.
//   Timing: a held subtraction runs before the character that resolves it;
//   / and % run through the one-bit-per-cycle divider.
//   The single stack RAM port sets the read sequence.
//   One character is in flight at a time.
//   Stall: the result sits in an output register; a newline waits only if
//   that register is still full when its own result is ready.
//   Reset: stack empty, no error, no result pending. Stack contents are not
//   cleared; only entries below the pointer are ever read.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator import pfe_pkg::*; #(
  parameter int STACK_DEPTH = DefStackDepth,
  parameter int VALUE_WIDTH = DefValueWidth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] char_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // [31:0] value, [33:32] status, zero fill
);
  pfe_cmd_t    cmd;
  pfe_sts_t    sts;
  logic [31:0] value;
  logic [1:0]  status;

  // control sequencer
  pfe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .sts(sts), .cmd(cmd));

  // stack, arithmetic and result register
  pfe_datapath #(.StackDepth(STACK_DEPTH), .ValueWidth(VALUE_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .char_in(s_axis_tdata), .cmd(cmd), .sts(sts),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_value(value), .out_status(status));

  assign m_axis_tdata = {6'd0, status, value};
endmodule

// File: sv/pfe_ram.sv
// ----------------------------------------------------------------------------
// pfe_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module pfe_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: sv/pfe_ctrl.sv
// ----------------------------------------------------------------------------
// pfe_ctrl
// Sequencer for one character: literal push, held subtraction, operator, line end.
// ----------------------------------------------------------------------------
module pfe_ctrl import pfe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  pfe_sts_t sts,
  output pfe_cmd_t cmd
);
  state_t state, state_next;
  logic   sub_mode, sub_mode_next; // current operator is the held subtraction

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      sub_mode <= 1'b0;
    end else begin
      state    <= state_next;
      sub_mode <= sub_mode_next;
    end
  end

  always_comb begin
    state_next    = state;
    sub_mode_next = sub_mode;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_PUSHNUM;
        end
      end
      S_PUSHNUM: begin
        if (sts.is_digit) state_next = S_IDLE;
        else              state_next = S_PENDSUB;
      end
      S_PENDSUB: begin
        if (sts.minus_pending && sts.sp_ge2) begin
          sub_mode_next = 1'b1;
          state_next    = S_RDP;
        end else begin
          state_next = S_DISPATCH;
        end
      end
      S_RDP:  state_next = S_RDQ;
      S_RDQ:  state_next = S_EXEC;
      S_EXEC: state_next = (sts.is_divop && !sub_mode) ? S_DIV : S_PUSHRES;
      S_DIV:  if (sts.div_done) state_next = S_PUSHRES;
      S_PUSHRES: begin
        if (sub_mode) begin
          sub_mode_next = 1'b0;
          state_next    = S_DISPATCH;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DISPATCH: begin
        if (sts.is_op && sts.sp_ge2) state_next = S_RDP;
        else if (sts.is_nl)          state_next = S_RDTOP;
        else                         state_next = S_IDLE;
      end
      S_RDTOP:   state_next = S_WAITOUT;
      S_WAITOUT: if (!sts.out_busy) state_next = S_EMIT;
      S_EMIT:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_char = in_valid;
      end
      S_PUSHNUM: begin
        cmd.digit    = sts.is_digit;
        cmd.push_num = !sts.is_digit && sts.in_number;
      end
      S_PENDSUB: begin
        cmd.clr_minus = sts.minus_pending;
        cmd.underflow = sts.minus_pending && !sts.sp_ge2;
      end
      S_RDP: begin
        cmd.rd_top  = 1'b1;
        cmd.use_sub = sub_mode;
      end
      S_RDQ: begin
        cmd.rd_next = 1'b1;
        cmd.latch_p = 1'b1;
      end
      S_EXEC: begin
        cmd.latch_q  = 1'b1;
        cmd.start_op = 1'b1;
        cmd.use_sub  = sub_mode;
      end
      S_DIV:     cmd.div_step = 1'b1;
      S_PUSHRES: cmd.push_res = 1'b1;
      S_DISPATCH: begin
        cmd.set_minus = sts.is_minus;
        cmd.underflow = sts.is_op && !sts.sp_ge2;
      end
      S_RDTOP: begin
        cmd.rd_top    = 1'b1;
        cmd.underflow = !sts.sp_ge1;
      end
      S_WAITOUT: cmd.rd_top = 1'b1;  // keep the top of stack on the read port
      S_EMIT:  cmd.emit = 1'b1;
      default: ;
    endcase
  end

  a_one_char: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_sub_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !sub_mode) else $error("subtraction left pending");
  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> $past(state) == S_EXEC || $past(state) == S_DIV)
    else $error("divider entered out of order");
endmodule

// File: sv/pfe_datapath.sv
// ----------------------------------------------------------------------------
// pfe_datapath
// Accumulator, stack memory and pointer, ALU with iterative divider, output register.
// ----------------------------------------------------------------------------
module pfe_datapath import pfe_pkg::*; #(
  parameter int StackDepth = DefStackDepth,
  parameter int ValueWidth = DefValueWidth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  char_in,
  input  pfe_cmd_t    cmd,
  output pfe_sts_t    sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_value,
  output logic [1:0]  out_status
);
  localparam int AW = $clog2(StackDepth);
  localparam int SW = $clog2(StackDepth + 1);
  localparam int CW = $clog2(ValueWidth + 1);
  localparam logic [SW-1:0] SpFull = SW'(StackDepth);

  logic [7:0]            ch;
  logic [ValueWidth-1:0] acc, p, res;
  logic                  in_number, minus_pending, neg_lit, op_sub;
  logic [1:0]            err;
  logic [SW-1:0]         sp;

  // divider
  logic [ValueWidth-1:0] dq, drem, dd;
  logic [CW-1:0]         dcnt;
  logic                  dqneg, dpneg, dmod;

  logic                  we;
  logic [AW-1:0]         addr;
  logic [ValueWidth-1:0] wdata, rdata;

  pfe_ram #(.Width(ValueWidth), .Depth(StackDepth)) u_stack (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

  logic is_digit;
  assign is_digit = ch >= ChZero && ch <= ChNine;

  logic [7:0] opch;
  assign opch = op_sub ? ChMinus : ch;

  logic [ValueWidth-1:0] lit, mag_p;
  assign lit   = neg_lit ? -acc : acc;
  assign mag_p = p[ValueWidth-1] ? -p : p;

  logic push_any, push_ok;
  assign push_any = cmd.push_num || cmd.push_res;
  assign push_ok  = push_any && sp < SpFull;
  assign we       = push_ok;
  assign wdata    = cmd.push_num ? lit : res;

  always_comb begin
    addr = sp[AW-1:0];
    if (cmd.rd_top)  addr = AW'(sp - SW'(1));
    if (cmd.rd_next) addr = AW'(sp - SW'(2));
  end

  // restoring division step
  logic [ValueWidth:0] trial;
  assign trial = {drem, dd[ValueWidth-1]} - {1'b0, mag_p};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_number     <= 1'b0;
      minus_pending <= 1'b0;
      neg_lit       <= 1'b0;
      err           <= StOk;
      sp            <= '0;
      acc           <= '0;
      out_valid     <= 1'b0;
      dcnt          <= '0;
      op_sub        <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.load_char) ch <= char_in;
      if (cmd.digit) begin
        if (minus_pending) begin
          minus_pending <= 1'b0;
          neg_lit       <= 1'b1;
          in_number     <= 1'b1;
          acc           <= ValueWidth'(ch - ChZero);
        end else if (!in_number) begin
          neg_lit   <= 1'b0;
          in_number <= 1'b1;
          acc       <= ValueWidth'(ch - ChZero);
        end else begin
          acc <= ValueWidth'((acc << 3) + (acc << 1) + ValueWidth'(ch - ChZero));
        end
      end
      if (cmd.push_num) begin
        in_number <= 1'b0;
        neg_lit   <= 1'b0;
        acc       <= '0;
      end
      if (push_ok) sp <= sp + SW'(1);
      if (push_any && !push_ok && err == StOk) err <= StOver;
      if (cmd.underflow && err == StOk) err <= StUnder;
      if (cmd.clr_minus) minus_pending <= 1'b0;
      if (cmd.set_minus) minus_pending <= 1'b1;
      if (cmd.rd_top) op_sub <= cmd.use_sub;
      if (cmd.latch_p) p <= rdata;
      if (cmd.latch_q) begin
        sp <= sp - SW'(2);
      end
      if (cmd.start_op) begin
        case (opch)
          ChPlus:  res <= rdata + p;
          ChMinus: res <= rdata - p;
          ChMul:   res <= ValueWidth'(rdata * p);
          ChOr:    res <= rdata | p;
          ChAnd:   res <= rdata & p;
          ChXor:   res <= rdata ^ p;
          default: begin
            res   <= '0;
            dmod  <= opch == ChMod;
            dqneg <= rdata[ValueWidth-1];
            dpneg <= p[ValueWidth-1];
            drem  <= '0;
            dq    <= '0;
            dd    <= rdata[ValueWidth-1] ? -rdata : rdata;
            dcnt  <= (p == '0) ? '0 : CW'(ValueWidth);
            if (p == '0 && err == StOk) err <= StDivZ;
          end
        endcase
      end
      if (cmd.div_step && dcnt != '0) begin
        dcnt <= dcnt - CW'(1);
        dd   <= dd << 1;
        if (!trial[ValueWidth]) begin
          drem <= trial[ValueWidth-1:0];
          dq   <= {dq[ValueWidth-2:0], 1'b1};
        end else begin
          drem <= {drem[ValueWidth-2:0], dd[ValueWidth-1]};
          dq   <= {dq[ValueWidth-2:0], 1'b0};
        end
      end
      if (cmd.div_step && dcnt == '0 && p != '0) begin
        if (dmod) res <= dqneg ? -drem : drem;
        else      res <= (dqneg != dpneg) ? -dq : dq;
      end
      if (cmd.emit) begin
        out_valid  <= 1'b1;
        out_value  <= sts.sp_ge1 ? 32'($signed(rdata)) : 32'd0;
        out_status <= (err == StOk && !sts.sp_ge1) ? StUnder : err;
        sp         <= '0;
        err        <= StOk;
      end
    end
  end

  assign sts.is_digit      = is_digit;
  assign sts.is_minus      = ch == ChMinus;
  assign sts.is_op         = ch == ChPlus || ch == ChMul || ch == ChDiv || ch == ChMod ||
                             ch == ChOr || ch == ChAnd || ch == ChXor;
  assign sts.is_nl         = ch == ChNl;
  assign sts.in_number     = in_number;
  assign sts.minus_pending = minus_pending;
  assign sts.sp_ge2        = sp >= SW'(2);
  assign sts.sp_ge1        = sp != '0;
  assign sts.is_divop      = opch == ChDiv || opch == ChMod;
  assign sts.div_done      = dcnt == '0;
  assign sts.out_busy      = out_valid && !out_ready;

  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SpFull) else $error("stack pointer beyond depth");
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(err) != StOk && !$past(cmd.emit) |-> err == $past(err))
    else $error("first error overwritten");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    $past(out_valid) && !$past(out_ready) |-> out_valid && $stable(out_value))
    else $error("result dropped while stalled");
endmodule
